>>> rtl/dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dec_pkg;

  // Fixed port widths
  localparam int DATA_W  = 64;
  localparam int CHK_W   = 14;
  localparam int IDX_W   = 7;
  localparam int ENTRY_W = 16;

  // Default code geometry
  localparam int CODE_BITS_DEF  = 78;
  localparam int CHECK_BITS_DEF = 14;

  // Syndrome map entry codes
  localparam logic [ENTRY_W-1:0] ENTRY_INVALID = 16'hFFFF;
  localparam logic [7:0]         SINGLE_TAG    = 8'hFF;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEG_CLEAN  = 2'd0,
    SEG_ONE    = 2'd1,
    SEG_TWO    = 2'd2,
    SEG_UNCORR = 2'd3
  } seg_status_t;

  typedef enum logic [1:0] {
    BLK_CLEAN     = 2'd0,
    BLK_CORRECTED = 2'd1,
    BLK_UNCORR    = 2'd2,
    BLK_UNUSED    = 2'd3
  } blk_status_t;

endpackage

`default_nettype wire

>>> rtl/dec_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/dec_synd.sv
`timescale 1ns / 1ps
`default_nettype none

module dec_synd
  import dec_pkg::*;
#(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int CHECK_BITS = CHECK_BITS_DEF,
  parameter int IW         = $clog2(CODE_BITS)
) (
  input  wire logic                  clk,
  input  wire logic                  col_we,
  input  wire logic [IW-1:0]         col_idx,
  input  wire logic [CHECK_BITS-1:0] col_val,
  input  wire logic                  start,
  input  wire logic [CODE_BITS-1:0]  word,
  output logic      [CHECK_BITS-1:0] syn
);

  localparam int GRP  = 16;
  localparam int NGRP = (CODE_BITS + GRP - 1) / GRP;

  logic [CHECK_BITS-1:0] cols [CODE_BITS];
  logic [CHECK_BITS-1:0] part [NGRP];
  logic [CHECK_BITS-1:0] part_next [NGRP];

  // Hold one column register per code position
  always_ff @(posedge clk) begin
    for (int p = 0; p < CODE_BITS; p++) begin
      if (col_we && col_idx == IW'(p)) begin
        cols[p] <= col_val;
      end
    end
  end

  // Fold each group of positions selected by the word
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CODE_BITS) begin
          if (word[g * GRP + k]) begin
            part_next[g] = part_next[g] ^ cols[g * GRP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= part_next;
    end
  end

  // Combine the group partials
  always_comb begin
    syn = '0;
    for (int g = 0; g < NGRP; g++) begin
      syn = syn ^ part[g];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dec_78_64_syndrome_codec.sv
// Double-error-correcting (78,64) codec with a loadable parity-check matrix.
// Requests enter on in_valid/in_stall, results leave on out_valid/out_stall;
// every request gives exactly one result, in order.
// Load request: writes one column, enters its single syndrome and its pair
// syndromes with all lower columns into the syndrome map, one map
// read-modify-write at a time. Encode request: ST_SYN, then ST_RESULT.
// Decode request: ST_SYN, then ST_RESULT when the syndrome is zero, with
// ST_DFIX between when the map must be looked up. The syndrome map RAM
// port and the two-stage column fold set these steps; one request is in flight.
// After reset the map is swept to invalid, one entry a cycle, over all
// 2^CHECK_BITS entries (16384 by default); in_stall stays high meanwhile.
// Block aggregates clear at reset and after each decoded segment marked last.
// A finished result sits in the output register while out_stall is high;
// the next request is still taken and its result waits until that slot frees.
`timescale 1ns / 1ps
`default_nettype none

module dec_78_64_syndrome_codec
  import dec_pkg::*;
#(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int CHECK_BITS = CHECK_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [IDX_W-1:0]  column_index,
  input  wire logic [CHK_W-1:0]  column_value,
  input  wire logic [DATA_W-1:0] data_word,
  input  wire logic [CHK_W-1:0]  check_bits,
  input  wire logic              last_segment,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      data_out,
  output logic [CHK_W-1:0]       check_out,
  output logic [1:0]             segment_status,
  output logic [1:0]             block_status,
  output logic                   block_done,
  output logic                   collision
);

  localparam int DATA_BITS = CODE_BITS - CHECK_BITS;
  localparam int IW        = $clog2(CODE_BITS);
  localparam int MAP_DEPTH = 1 << CHECK_BITS;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_SYN    = 10'b0000000100,
    ST_DFIX   = 10'b0000001000,
    ST_LSWR   = 10'b0000010000,
    ST_LCRD   = 10'b0000100000,
    ST_LMRD   = 10'b0001000000,
    ST_LMWR   = 10'b0010000000,
    ST_RESULT = 10'b0100000000,
    ST_SPARE  = 10'b1000000000
  } state_t;

  // Place data and check bits at their code positions
  function automatic logic [CODE_BITS-1:0] build_word(input logic [DATA_W-1:0] d,
                                                      input logic [CHK_W-1:0] c);
    logic [CODE_BITS-1:0] w;
    w = '0;
    for (int p = 0; p < CODE_BITS; p++) begin
      if (p < DATA_BITS) begin
        if (p < DATA_W) begin
          w[p] = d[p];
        end
      end else if (p - DATA_BITS < CHK_W) begin
        w[p] = c[p - DATA_BITS];
      end
    end
    return w;
  endfunction

  // Flip mask for one code position: check bits above, data bits below
  function automatic logic [CHK_W+DATA_W-1:0] pos_mask(input logic [7:0] p);
    logic [CHK_W+DATA_W-1:0] m;
    m = '0;
    for (int k = 0; k < DATA_W; k++) begin
      m[k] = (k < DATA_BITS) && (p == 8'(k));
    end
    for (int c = 0; c < CHK_W; c++) begin
      m[DATA_W + c] = (c < CHECK_BITS) && (p == 8'(DATA_BITS + c));
    end
    return m;
  endfunction

  state_t state;

  logic                  op_dec;
  logic [CHECK_BITS-1:0] col_r;
  logic [DATA_W-1:0]     data_r;
  logic [CHK_W-1:0]      chk_r;
  logic                  last_r;
  logic [IW-1:0]         i_cnt;
  logic [IW-1:0]         j_idx;
  logic [CHECK_BITS-1:0] s_r;
  logic [CHECK_BITS-1:0] clr;
  logic                  clash;
  logic                  any_cor;
  logic                  any_unc;

  logic [DATA_W-1:0] res_data;
  logic [CHK_W-1:0]  res_check;
  logic [1:0]        res_seg;
  logic [1:0]        res_blk;
  logic              res_done;
  logic              res_coll;

  logic                  accept;
  logic                  load_ok;
  logic [CHECK_BITS-1:0] in_col;
  logic [CHECK_BITS-1:0] syn;
  logic [CODE_BITS-1:0]  word_in;

  logic                  map_we;
  logic [CHECK_BITS-1:0] map_waddr;
  logic [ENTRY_W-1:0]    map_wdata;
  logic [CHECK_BITS-1:0] map_raddr;
  logic [ENTRY_W-1:0]    map_rdata;
  logic [CHECK_BITS-1:0] col_rdata;
  logic [CHECK_BITS-1:0] walk_syn;
  logic                  entry_free;

  logic                    fin_en;
  seg_status_t             fin_st;
  logic [CHK_W+DATA_W-1:0] fix_mask;
  logic                    unc_next;
  logic                    cor_next;

  assign in_col   = CHECK_BITS'(column_value);
  assign accept   = (state == ST_IDLE) && in_valid;
  assign in_stall = (state != ST_IDLE);
  assign load_ok  = (op == OP_LOAD) && (column_index < IDX_W'(CODE_BITS));
  assign word_in  = build_word(data_word, (op == OP_ENCODE) ? '0 : check_bits);
  assign walk_syn = col_rdata ^ col_r;
  assign entry_free = (map_rdata == ENTRY_INVALID);

  dec_synd #(
    .CODE_BITS  (CODE_BITS),
    .CHECK_BITS (CHECK_BITS),
    .IW         (IW)
  ) u_synd (
    .clk     (clk),
    .col_we  (accept && load_ok),
    .col_idx (IW'(column_index)),
    .col_val (in_col),
    .start   (accept),
    .word    (word_in),
    .syn     (syn)
  );

  dec_ram #(
    .WIDTH (CHECK_BITS),
    .DEPTH (CODE_BITS),
    .AW    (IW)
  ) u_col_ram (
    .clk   (clk),
    .we    (accept && load_ok),
    .waddr (IW'(column_index)),
    .wdata (in_col),
    .raddr (i_cnt),
    .rdata (col_rdata)
  );

  dec_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAP_DEPTH),
    .AW    (CHECK_BITS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Select the map read address
  always_comb begin
    unique case (state)
      ST_SYN:  map_raddr = syn;
      ST_LMRD: map_raddr = walk_syn;
      default: map_raddr = in_col;
    endcase
  end

  // Drive map writes: clearing sweep, single entry, pair entries
  always_comb begin
    map_we    = 1'b0;
    map_waddr = s_r;
    map_wdata = {8'(i_cnt), 8'(j_idx)};
    unique case (state)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr;
        map_wdata = ENTRY_INVALID;
      end
      ST_LSWR: begin
        map_we    = (col_r != '0) && entry_free;
        map_waddr = col_r;
        map_wdata = {SINGLE_TAG, 8'(j_idx)};
      end
      ST_LMWR: begin
        map_we = (s_r != '0) && entry_free;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  // Resolve the segment status and its flips
  always_comb begin
    fin_en   = 1'b0;
    fin_st   = SEG_CLEAN;
    fix_mask = '0;
    if (state == ST_SYN && op_dec && syn == '0) begin
      fin_en = 1'b1;
    end else if (state == ST_DFIX) begin
      fin_en = 1'b1;
      if (entry_free) begin
        fin_st = SEG_UNCORR;
      end else if (map_rdata[15:8] == SINGLE_TAG) begin
        fin_st   = SEG_ONE;
        fix_mask = pos_mask(map_rdata[7:0]);
      end else begin
        fin_st   = SEG_TWO;
        fix_mask = pos_mask(map_rdata[7:0]) ^ pos_mask(map_rdata[15:8]);
      end
    end
    unc_next = any_unc || (fin_st == SEG_UNCORR);
    cor_next = any_cor || (fin_st == SEG_ONE) || (fin_st == SEG_TWO);
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      any_cor   <= 1'b0;
      any_unc   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_RESULT) begin
        out_valid <= 1'b0;
      end
      if (fin_en) begin
        res_data  <= data_r ^ fix_mask[DATA_W-1:0];
        res_check <= chk_r ^ fix_mask[CHK_W+DATA_W-1:DATA_W];
        res_seg   <= fin_st;
        if (last_r) begin
          res_blk  <= unc_next ? BLK_UNCORR : (cor_next ? BLK_CORRECTED : BLK_CLEAN);
          res_done <= 1'b1;
          any_cor  <= 1'b0;
          any_unc  <= 1'b0;
        end else begin
          any_cor <= cor_next;
          any_unc <= unc_next;
        end
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_dec    <= (op == OP_DECODE);
            col_r     <= in_col;
            data_r    <= data_word;
            chk_r     <= check_bits;
            last_r    <= last_segment;
            j_idx     <= IW'(column_index);
            i_cnt     <= '0;
            clash     <= 1'b0;
            res_data  <= '0;
            res_check <= '0;
            res_seg   <= SEG_CLEAN;
            res_blk   <= BLK_CLEAN;
            res_done  <= 1'b0;
            res_coll  <= 1'b0;
            if (load_ok) begin
              state <= ST_LSWR;
            end else if (op == OP_ENCODE || op == OP_DECODE) begin
              state <= ST_SYN;
            end else begin
              state <= ST_RESULT;
            end
          end
        end
        ST_SYN: begin
          if (!op_dec) begin
            res_data  <= data_r;
            res_check <= CHK_W'(syn);
            state     <= ST_RESULT;
          end else if (syn == '0) begin
            state <= ST_RESULT;
          end else begin
            state <= ST_DFIX;
          end
        end
        ST_DFIX: begin
          state <= ST_RESULT;
        end
        ST_LSWR: begin
          if (col_r == '0 || !entry_free) begin
            clash    <= 1'b1;
            res_coll <= 1'b1;
          end
          state <= (j_idx == '0) ? ST_RESULT : ST_LCRD;
        end
        ST_LCRD: begin
          state <= ST_LMRD;
        end
        ST_LMRD: begin
          s_r   <= walk_syn;
          state <= ST_LMWR;
        end
        ST_LMWR: begin
          if (s_r == '0 || !entry_free) begin
            clash    <= 1'b1;
            res_coll <= 1'b1;
          end
          i_cnt <= i_cnt + 1'b1;
          state <= (IW'(i_cnt + 1'b1) == j_idx) ? ST_RESULT : ST_LCRD;
        end
        ST_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            data_out       <= res_data;
            check_out      <= res_check;
            segment_status <= res_seg;
            block_status   <= res_blk;
            block_done     <= res_done;
            collision      <= res_coll || clash;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> dv/dec_78_64_syndrome_codec_tb.sv
`timescale 1ns / 1ps

module dec_78_64_syndrome_codec_tb;
  import dec_pkg::*;

  localparam int NCODE = 78;
  localparam int NDATA = 64;
  localparam int MAPN  = 1 << CHK_W;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CHK_W-1:0]  chk;
    logic [1:0]        seg;
    logic [1:0]        blk;
    logic              done;
    logic              coll;
  } codec_result_t;

  // Predict codec results and match them against what comes out, in order
  class codec_scoreboard;
    logic [CHK_W-1:0]   columns[NCODE];
    logic [ENTRY_W-1:0] synmap[MAPN];
    bit                 any_fixed, any_uncorr;
    codec_result_t      pending[$];
    int                 mismatches;
    int                 checked;
    int                 seg_seen[4];

    function new();
      for (int i = 0; i < NCODE; i++) columns[i] = '0;
      for (int i = 0; i < MAPN; i++) synmap[i] = ENTRY_INVALID;
    endfunction

    function bit enter_syndrome(logic [CHK_W-1:0] s, logic [ENTRY_W-1:0] e);
      if (s == '0 || synmap[s] != ENTRY_INVALID) return 1'b1;
      synmap[s] = e;
      return 1'b0;
    endfunction

    // Note one accepted request and queue its expected result
    function void note_request(op_t o, logic [IDX_W-1:0] idx, logic [CHK_W-1:0] cv,
                               logic [DATA_W-1:0] d, logic [CHK_W-1:0] cb, logic lst);
      codec_result_t r;
      logic [CHK_W-1:0] s;
      logic [ENTRY_W-1:0] e;
      logic [NCODE-1:0] word;
      int p;
      r = '0;
      case (o)
        OP_LOAD: begin
          if (idx < NCODE) begin
            columns[idx] = cv;
            r.coll = enter_syndrome(cv, {SINGLE_TAG, 1'b0, idx});
            for (int i = 0; i < idx; i++)
              r.coll |= enter_syndrome(columns[i] ^ cv, {i[7:0], 1'b0, idx});
          end
        end
        OP_ENCODE: begin
          s = '0;
          for (int i = 0; i < NDATA; i++) if (d[i]) s ^= columns[i];
          r.data = d;
          r.chk = s;
        end
        OP_DECODE: begin
          word = {cb, d};
          s = '0;
          for (int i = 0; i < NCODE; i++) if (word[i]) s ^= columns[i];
          if (s == '0) r.seg = SEG_CLEAN;
          else begin
            e = synmap[s];
            if (e == ENTRY_INVALID) r.seg = SEG_UNCORR;
            else if (e[15:8] == SINGLE_TAG) begin
              p = e[7:0];
              word[p] = ~word[p];
              r.seg = SEG_ONE;
            end else begin
              p = e[15:8];
              word[p] = ~word[p];
              p = e[7:0];
              word[p] = ~word[p];
              r.seg = SEG_TWO;
            end
          end
          if (r.seg == SEG_ONE || r.seg == SEG_TWO) any_fixed = 1'b1;
          if (r.seg == SEG_UNCORR) any_uncorr = 1'b1;
          r.data = word[NDATA-1:0];
          r.chk = word[NCODE-1:NDATA];
          if (lst) begin
            r.blk = any_uncorr ? BLK_UNCORR : (any_fixed ? BLK_CORRECTED : BLK_CLEAN);
            r.done = 1'b1;
            any_fixed = 1'b0;
            any_uncorr = 1'b0;
          end
          seg_seen[r.seg]++;
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    // Compare one observed result with the oldest prediction
    function void check_result(codec_result_t got);
      codec_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d mismatch\n  exp %p\n  got %p", checked, want, got);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        op = '0;
  logic [IDX_W-1:0]  column_index = '0;
  logic [CHK_W-1:0]  column_value = '0;
  logic [DATA_W-1:0] data_word = '0;
  logic [CHK_W-1:0]  check_bits = '0;
  logic              last_segment = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] data_out;
  logic [CHK_W-1:0]  check_out;
  logic [1:0]        segment_status;
  logic [1:0]        block_status;
  logic              block_done;
  logic              collision;

  codec_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  longint cycles = 0;
  int  requests = 0;
  logic [CHK_W-1:0] loaded[NCODE];

  dec_78_64_syndrome_codec i_dut (.*);

  always #6 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive receiver stall and check results
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({data_out, check_out, segment_status, block_status,
                       block_done, collision});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Present one request and hold it until accepted
  task automatic send_request(op_t o, logic [IDX_W-1:0] idx, logic [CHK_W-1:0] cv,
                              logic [DATA_W-1:0] d, logic [CHK_W-1:0] cb, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    op <= o;
    column_index <= idx;
    column_value <= cv;
    data_word <= d;
    check_bits <= cb;
    last_segment <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(o, idx, cv, d, cb, lst);
    requests++;
  endtask

  task automatic load_column(int idx, logic [CHK_W-1:0] cv);
    send_request(OP_LOAD, idx[IDX_W-1:0], cv, DATA_W'($urandom), CHK_W'($urandom),
                 1'($urandom));
    if (idx < NCODE) loaded[idx] = cv;
  endtask

  // Load a full random matrix, check columns as unit vectors
  task automatic load_matrix();
    for (int i = 0; i < NDATA; i++) load_column(i, CHK_W'($urandom));
    for (int i = 0; i < CHK_W; i++) load_column(NDATA + i, 14'(1) << i);
  endtask

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Decode of an encoded word with zero, one, two or many flips
  task automatic send_codeword(int nflip, logic lst);
    logic [DATA_W-1:0] d;
    logic [CHK_W-1:0]  c;
    logic [NCODE-1:0]  w;
    int p;
    d = rand64();
    c = '0;
    for (int i = 0; i < NDATA; i++) if (d[i]) c ^= loaded[i];
    send_request(OP_ENCODE, IDX_W'($urandom), CHK_W'($urandom), d, CHK_W'($urandom),
                 1'($urandom));
    w = {c, d};
    for (int k = 0; k < nflip; k++) begin
      p = $urandom_range(NCODE - 1);
      w[p] = ~w[p];
    end
    send_request(OP_DECODE, IDX_W'($urandom), CHK_W'($urandom), w[NDATA-1:0],
                 w[NCODE-1:NDATA], lst);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int nf;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: matrix load, extremes, odd ops and special cases
    load_matrix();
    load_column(NCODE, 14'h3FFF);
    load_column(127, 14'h0001);
    load_column(5, loaded[5]);
    load_column(3, '0);
    load_column(3, loaded[3]);
    send_request(OP_ENCODE, '0, '0, '0, '0, 1'b0);
    send_request(OP_ENCODE, '1, '1, '1, '1, 1'b1);
    send_request(OP_NONE, '1, '1, '1, '1, 1'b1);
    send_request(OP_DECODE, '0, '0, '0, '0, 1'b1);
    send_request(OP_DECODE, '1, '1, '1, '1, 1'b0);
    send_request(OP_DECODE, '0, '0, '0, 14'h3FFF, 1'b1);
    send_codeword(1, 1'b0);
    send_codeword(2, 1'b1);
    send_codeword(5, 1'b1);
    drain();

    // Random phases with different idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 30 : 0;
      if (ph == 1) load_matrix();
      for (int n = 0; n < 120; n++) begin
        case ($urandom_range(9))
          0: send_request(OP_DECODE, IDX_W'($urandom), CHK_W'($urandom), rand64(),
                          CHK_W'($urandom), 1'($urandom));
          1: send_request(op_t'($urandom_range(3)), IDX_W'($urandom), CHK_W'($urandom),
                          rand64(), CHK_W'($urandom), 1'($urandom));
          default: begin
            nf = $urandom_range(6);
            send_codeword(nf > 3 ? $urandom_range(2) : nf, $urandom_range(3) == 0);
          end
        endcase
      end
      drain();
    end

    $display("ran %0d requests, %0d results checked, %0d mismatches", requests,
             sb.checked, sb.mismatches);
    $display("decode status mix clean/one/two/uncorrectable: %0d/%0d/%0d/%0d",
             sb.seg_seen[0], sb.seg_seen[1], sb.seg_seen[2], sb.seg_seen[3]);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
